@@ rtl/rrcp_pkg.sv @@
// Shared types, register codes and constants for the ROI row/column projection unit.
`default_nettype none

package rrcp_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_BINS = 4096;
	localparam int DEF_SUM_BITS = 32;

	// epoch tag held with every bin; a frame start moves to the next epoch
	localparam int EPOCH_BITS = 8;

	// result queue
	localparam int OUT_DEPTH = 4;
	localparam int PTR_BITS  = $clog2(OUT_DEPTH);
	localparam int CNT_BITS  = $clog2(OUT_DEPTH) + 1;

	// configuration register indexes
	localparam logic [2:0] REG_ROI_LEFT     = 3'd0;
	localparam logic [2:0] REG_ROI_TOP      = 3'd1;
	localparam logic [2:0] REG_ROI_COLS     = 3'd2;
	localparam logic [2:0] REG_ROI_ROWS     = 3'd3;
	localparam logic [2:0] REG_SUM_MODE     = 3'd4;
	localparam logic [2:0] REG_FRAME_COLS   = 3'd5;
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd6;

	// pixel formats
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_S16 = 3'd3;
	localparam logic [2:0] FMT_U32 = 3'd4;
	localparam logic [2:0] FMT_S32 = 3'd5;

	// input word kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef logic [EPOCH_BITS-1:0] epoch_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DRAIN,
		ST_SWEEP
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_READ,
		OP_SWEEP
	} op_code_t;

	typedef struct packed {
		logic [11:0] roi_left;
		logic [11:0] roi_top;
		logic [12:0] roi_cols;
		logic [12:0] roi_rows;
		logic        sum_mode;
		logic [12:0] frame_cols;
		logic [2:0]  pixel_format;
	} cfg_t;

	// one bin store operation with the result fields it carries along
	typedef struct packed {
		logic        valid;
		op_code_t    code;
		logic        add_en;
		logic        force_clr;
		epoch_t      epoch;
		logic        emit;
		logic        is_read;
		logic [31:0] tag;
		logic [12:0] total;
		logic        empty;
		logic [11:0] bin_number;
		logic        in_range;
	} op_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_emit;
	} store_status_t;

	typedef struct packed {
		logic        is_bin_read;
		logic [31:0] frame_tag;
		logic [12:0] bin_total;
		logic        region_empty;
		logic [11:0] bin_number;
		logic [31:0] bin_value;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/rrcp_out_fifo.sv @@
// Small result queue between the bin store and the output channel.
`default_nettype none

module rrcp_out_fifo
	import rrcp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire res_t                push_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output res_t                     out_data,
	output logic [CNT_BITS-1:0]      count
);

	res_t                entry_q [OUT_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && out_ready;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_BITS'(1);
				2'b01:   count_q <= count_q - CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/rrcp_bin_store.sv @@
// Bin memory with epoch tags, read-modify-write stage and write forwarding.
`default_nettype none

module rrcp_bin_store
	import rrcp_pkg::*;
#(
	parameter int MAX_BINS = DEF_MAX_BINS,
	parameter int SUM_BITS = DEF_SUM_BITS
)
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire op_t                         op_s0,
	input  wire logic [$clog2(MAX_BINS)-1:0] addr_s0,
	input  wire logic [SUM_BITS-1:0]         addend_s0,
	output store_status_t                    status,
	output logic                             res_valid,
	output res_t                             res
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int EW = EPOCH_BITS + SUM_BITS;

	// each entry: {epoch tag, running sum}
	logic [EW-1:0] mem [MAX_BINS];

	logic [EW-1:0]       rdata_s1;
	op_t                 op_s1;
	logic [AW-1:0]       addr_s1;
	logic [SUM_BITS-1:0] addend_s1;

	logic                fwd_valid_q;
	logic [AW-1:0]       fwd_addr_q;
	logic [EW-1:0]       fwd_entry_q;

	logic [EW-1:0]       cur;
	epoch_t              cur_tag;
	logic [SUM_BITS-1:0] cur_val;
	logic [SUM_BITS-1:0] held;
	logic [SUM_BITS-1:0] sum;
	logic                we;
	logic [EW-1:0]       wdata;

	// memory read port, registered data
	always_ff @(posedge clk) begin
		if (op_s0.valid) begin
			rdata_s1 <= mem[addr_s0];
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_s1] <= wdata;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op_s0;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr_s0;
		addend_s1 <= addend_s0;
	end

	// the write of the previous cycle is not yet visible to the read just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_addr_q  <= addr_s1;
			fwd_entry_q <= wdata;
		end
	end

	// read-modify-write: a stale epoch or a forced clear reads as an empty bin
	always_comb begin
		cur     = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_entry_q : rdata_s1;
		cur_tag = cur[EW-1:SUM_BITS];
		cur_val = cur[SUM_BITS-1:0];
		held    = ((cur_tag == op_s1.epoch) && !op_s1.force_clr) ? cur_val : '0;
		sum     = held + addend_s1;
		we      = op_s1.valid &&
		          (((op_s1.code == OP_PIXEL) && op_s1.add_en) || (op_s1.code == OP_SWEEP));
		wdata   = {op_s1.epoch, (op_s1.code == OP_SWEEP) ? held : sum};
	end

	// result word
	always_comb begin
		res_valid          = op_s1.valid && op_s1.emit;
		res.is_bin_read    = op_s1.is_read;
		res.frame_tag      = op_s1.tag;
		res.bin_total      = op_s1.total;
		res.region_empty   = op_s1.empty;
		res.bin_number     = op_s1.bin_number;
		res.bin_value      = (op_s1.is_read && op_s1.in_range) ? 32'(held) : 32'd0;
		status.s1_valid    = op_s1.valid;
		status.s1_emit     = op_s1.valid && op_s1.emit;
	end

endmodule

`default_nettype wire

@@ rtl/rrcp_front.sv @@
// Input stage: raster position, region test, pixel widening, epoch and sweep sequencing.
`default_nettype none

module rrcp_front
	import rrcp_pkg::*;
#(
	parameter int MAX_BINS = DEF_MAX_BINS,
	parameter int SUM_BITS = DEF_SUM_BITS
)
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cfg_t                        cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	input  wire logic [31:0]                 pixel_raw,
	input  wire logic                        frame_end,
	input  wire logic [31:0]                 frame_id,
	input  wire logic [11:0]                 read_index,
	input  wire logic [CNT_BITS-1:0]         fifo_count,
	input  wire store_status_t               status,
	output op_t                              op_s0,
	output logic [$clog2(MAX_BINS)-1:0]      addr_s0,
	output logic [SUM_BITS-1:0]              addend_s0
);

	localparam int AW = $clog2(MAX_BINS);

	seq_state_t    state_q;
	seq_state_t    state_d;
	logic [11:0]   col_q;
	logic [12:0]   row_q;
	logic          past_q;
	logic [31:0]   last_tag_q;
	epoch_t        epoch_q;
	epoch_t        base_q;
	logic          force_q;
	logic [AW-1:0] sweep_addr_q;

	logic          accept;
	logic          is_pix;
	logic          frame_start;
	logic          empty;
	logic [11:0]   col_off;
	logic [12:0]   row_off;
	logic          in_col;
	logic          in_row;
	logic [12:0]   bin_idx;
	logic          bin_ok;
	logic          fmt_ok;
	logic [63:0]   wide;
	logic          add_en;
	logic [12:0]   stride;
	logic          wrap;
	logic          rd_ok;
	logic [12:0]   raw_total;
	logic [12:0]   total;
	epoch_t        epoch_next;
	logic          alias_next;
	logic          sweep_last;

	// region test and bin index for the pixel at the current position
	always_comb begin
		empty       = (cfg.roi_cols == 13'd0) || (cfg.roi_rows == 13'd0);
		frame_start = (col_q == 12'd0) && (row_q == 13'd0) && !past_q;
		col_off     = col_q - cfg.roi_left;
		row_off     = row_q - {1'b0, cfg.roi_top};
		in_col      = (col_q >= cfg.roi_left) && ({1'b0, col_off} < cfg.roi_cols);
		in_row      = (row_q >= {1'b0, cfg.roi_top}) && (row_off < cfg.roi_rows);
		bin_idx     = cfg.sum_mode ? row_off : {1'b0, col_off};
		bin_ok      = 32'(bin_idx) < 32'(MAX_BINS);
		rd_ok       = 32'(read_index) < 32'(MAX_BINS);
	end

	// pixel widening per format
	always_comb begin
		fmt_ok = 1'b1;
		case (cfg.pixel_format)
			FMT_U8:  wide = {56'd0, pixel_raw[7:0]};
			FMT_S8:  wide = {{56{pixel_raw[7]}}, pixel_raw[7:0]};
			FMT_U16: wide = {48'd0, pixel_raw[15:0]};
			FMT_S16: wide = {{48{pixel_raw[15]}}, pixel_raw[15:0]};
			FMT_U32: wide = {32'd0, pixel_raw};
			FMT_S32: wide = {{32{pixel_raw[31]}}, pixel_raw};
			default: begin
				wide   = 64'd0;
				fmt_ok = 1'b0;
			end
		endcase
		add_en = !empty && !past_q && in_col && in_row && bin_ok && fmt_ok;
	end

	// line stride, bin count and epoch step
	always_comb begin
		if (cfg.frame_cols == 13'd0) begin
			stride = 13'd1;
		end else if (cfg.frame_cols > 13'd4096) begin
			stride = 13'd4096;
		end else begin
			stride = cfg.frame_cols;
		end
		wrap      = ({1'b0, col_q} + 13'd1) >= stride;
		raw_total = cfg.sum_mode ? cfg.roi_rows : cfg.roi_cols;
		if (empty) begin
			total = 13'd0;
		end else if (32'(raw_total) > 32'(MAX_BINS)) begin
			total = 13'(MAX_BINS);
		end else begin
			total = raw_total;
		end
		epoch_next = epoch_q + EPOCH_BITS'(1);
		alias_next = (epoch_next + EPOCH_BITS'(1)) == base_q;
		sweep_last = sweep_addr_q == AW'(MAX_BINS - 1);
	end

	assign is_pix = (kind == KIND_PIXEL);
	assign accept = in_valid && in_ready;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (accept && is_pix && frame_start && alias_next) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.s1_valid) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// sequencer outputs: handshake and the operation issued to the store
	always_comb begin
		in_ready  = (state_q == ST_RUN) &&
		            (({1'b0, fifo_count} + (CNT_BITS + 1)'(status.s1_emit)) <
		             (CNT_BITS + 1)'(OUT_DEPTH));
		op_s0     = '0;
		addr_s0   = '0;
		addend_s0 = SUM_BITS'(wide);
		case (state_q)
			ST_SWEEP: begin
				op_s0.valid     = 1'b1;
				op_s0.code      = OP_SWEEP;
				op_s0.epoch     = epoch_q;
				op_s0.force_clr = force_q;
				addr_s0         = sweep_addr_q;
			end
			ST_RUN: begin
				if (accept && is_pix) begin
					op_s0.valid  = 1'b1;
					op_s0.code   = OP_PIXEL;
					op_s0.add_en = add_en;
					op_s0.epoch  = frame_start ? epoch_next : epoch_q;
					op_s0.emit   = frame_end;
					op_s0.tag    = frame_id;
					op_s0.total  = total;
					op_s0.empty  = empty;
					addr_s0      = AW'(bin_idx);
				end else if (accept) begin
					op_s0.valid      = 1'b1;
					op_s0.code       = OP_READ;
					op_s0.epoch      = epoch_q;
					op_s0.emit       = 1'b1;
					op_s0.is_read    = 1'b1;
					op_s0.tag        = last_tag_q;
					op_s0.bin_number = read_index;
					op_s0.in_range   = rd_ok;
					addr_s0          = rd_ok ? AW'(read_index) : '0;
				end
			end
			default: begin
				op_s0 = '0;
			end
		endcase
	end

	// state, raster position, epoch and sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			col_q        <= '0;
			row_q        <= '0;
			past_q       <= 1'b0;
			last_tag_q   <= '0;
			epoch_q      <= '0;
			base_q       <= '0;
			force_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_pix) begin
				if (frame_start) begin
					epoch_q <= epoch_next;
				end
				if (frame_end) begin
					col_q      <= '0;
					row_q      <= '0;
					past_q     <= 1'b0;
					last_tag_q <= frame_id;
				end else if (wrap) begin
					col_q <= '0;
					if (row_q >= 13'd8191) begin
						past_q <= 1'b1;
					end else begin
						row_q <= row_q + 13'd1;
					end
				end else begin
					col_q <= col_q + 12'd1;
				end
			end
			if (state_q == ST_SWEEP) begin
				if (sweep_last) begin
					sweep_addr_q <= '0;
					force_q      <= 1'b0;
					base_q       <= epoch_q;
				end else begin
					sweep_addr_q <= sweep_addr_q + AW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/roi_row_column_projection_unit.sv @@
// Top level of the ROI row/column projection unit: registers, input stage, bin store, result queue.
`default_nettype none

// Pixels of a frame enter in raster order, one word per clock unless the tag sweep or a
// nearly full result queue holds input off, and are summed into per-column (line-sum mode)
// or per-row (column-sum mode) bins of a region of interest; read words return one bin.
// A result passes through the stage-1 register and the result queue before it reaches the
// output, and up to four results are held when the output stalls. The bins live in a single
// memory with one read and one write port, updated by a read-modify-write with forwarding;
// each entry carries an epoch tag so that the clear at frame start needs no pass over memory.
// After reset the unit runs a clearing pass over all MAX_BINS entries before it accepts a
// word, and once every 255 frames it stops input while it sweeps the memory to renormalise
// the tags. Configuration writes are taken at any time and should be made only while the unit is idle.

module roi_row_column_projection_unit
	import rrcp_pkg::*;
#(
	parameter int MAX_BINS = DEF_MAX_BINS,
	parameter int SUM_BITS = DEF_SUM_BITS
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [12:0]        cfg_data,
	// input words
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [31:0]        pixel_raw,
	input  wire logic               frame_end,
	input  wire logic [31:0]        frame_id,
	input  wire logic [11:0]        read_index,
	// result words
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    is_bin_read,
	output logic [31:0]             frame_tag,
	output logic [12:0]             bin_total,
	output logic                    region_empty,
	output logic [11:0]             bin_number,
	output logic signed [31:0]      bin_value
);

	localparam int AW = $clog2(MAX_BINS);

	cfg_t                cfg_q;
	op_t                 op_s0;
	logic [AW-1:0]       addr_s0;
	logic [SUM_BITS-1:0] addend_s0;
	store_status_t       status;
	logic                res_valid;
	res_t                res;
	res_t                out_word;
	logic [CNT_BITS-1:0] fifo_count;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_left     <= '0;
			cfg_q.roi_top      <= '0;
			cfg_q.roi_cols     <= '0;
			cfg_q.roi_rows     <= '0;
			cfg_q.sum_mode     <= 1'b0;
			cfg_q.frame_cols   <= 13'd1;
			cfg_q.pixel_format <= FMT_U8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROI_LEFT:     cfg_q.roi_left     <= cfg_data[11:0];
				REG_ROI_TOP:      cfg_q.roi_top      <= cfg_data[11:0];
				REG_ROI_COLS:     cfg_q.roi_cols     <= cfg_data;
				REG_ROI_ROWS:     cfg_q.roi_rows     <= cfg_data;
				REG_SUM_MODE:     cfg_q.sum_mode     <= cfg_data[0];
				REG_FRAME_COLS:   cfg_q.frame_cols   <= cfg_data;
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[2:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	rrcp_front #(
		.MAX_BINS (MAX_BINS),
		.SUM_BITS (SUM_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.pixel_raw  (pixel_raw),
		.frame_end  (frame_end),
		.frame_id   (frame_id),
		.read_index (read_index),
		.fifo_count (fifo_count),
		.status     (status),
		.op_s0      (op_s0),
		.addr_s0    (addr_s0),
		.addend_s0  (addend_s0)
	);

	rrcp_bin_store #(
		.MAX_BINS (MAX_BINS),
		.SUM_BITS (SUM_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_s0     (op_s0),
		.addr_s0   (addr_s0),
		.addend_s0 (addend_s0),
		.status    (status),
		.res_valid (res_valid),
		.res       (res)
	);

	rrcp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_word),
		.count     (fifo_count)
	);

	// result fields
	assign is_bin_read  = out_word.is_bin_read;
	assign frame_tag    = out_word.frame_tag;
	assign bin_total    = out_word.bin_total;
	assign region_empty = out_word.region_empty;
	assign bin_number   = out_word.bin_number;
	assign bin_value    = $signed(out_word.bin_value);

endmodule

`default_nettype wire

@@ bench/rrcp_projection_check.sv @@
// Checker for the ROI projection unit: watches all three channels, predicts each result word.
`timescale 1ns / 1ps

module rrcp_projection_check
	import rrcp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               kind,
	input  logic [31:0]        pixel_raw,
	input  logic               frame_end,
	input  logic [31:0]        frame_id,
	input  logic [11:0]        read_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               is_bin_read,
	input  logic [31:0]        frame_tag,
	input  logic [12:0]        bin_total,
	input  logic               region_empty,
	input  logic [11:0]        bin_number,
	input  logic [31:0]        bin_value,
	output int unsigned        fault_count,
	output int unsigned        outstanding
);

	localparam int BIN_SLOTS  = DEF_MAX_BINS;
	localparam int STRIDE_MAX = 4096;
	localparam int ROW_LAST   = 8191;

	// shadow registers and bin store
	cfg_t        setup;
	logic [31:0] bin_sum [BIN_SLOTS];
	int unsigned col_pos;
	int unsigned row_pos;
	bit          row_past_end;
	logic [31:0] last_tag;
	res_t        due_results [$];

	initial begin
		fault_count = 0;
		outstanding = 0;
	end

	// widen a raw pixel per format; unknown formats add nothing
	function automatic bit extend_pixel(input logic [2:0] fmt, input logic [31:0] raw,
			output logic [31:0] addend);
		extend_pixel = 1'b1;
		case (fmt)
			FMT_U8:  addend = {24'd0, raw[7:0]};
			FMT_S8:  addend = {{24{raw[7]}}, raw[7:0]};
			FMT_U16: addend = {16'd0, raw[15:0]};
			FMT_S16: addend = {{16{raw[15]}}, raw[15:0]};
			FMT_U32: addend = raw;
			FMT_S32: addend = raw;
			default: begin
				addend = '0;
				extend_pixel = 1'b0;
			end
		endcase
	endfunction

	task automatic clear_bins();
		for (int i = 0; i < BIN_SLOTS; i++)
			bin_sum[i] = '0;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [12:0] data);
		case (idx)
			REG_ROI_LEFT:     setup.roi_left     = data[11:0];
			REG_ROI_TOP:      setup.roi_top      = data[11:0];
			REG_ROI_COLS:     setup.roi_cols     = data;
			REG_ROI_ROWS:     setup.roi_rows     = data;
			REG_SUM_MODE:     setup.sum_mode     = data[0];
			REG_FRAME_COLS:   setup.frame_cols   = data;
			REG_PIXEL_FORMAT: setup.pixel_format = data[2:0];
			default: ;
		endcase
	endtask

	// advance the projection by one accepted word and queue what it should produce
	task automatic project_word(input logic k, input logic [31:0] raw, input logic fend,
			input logic [31:0] fid, input logic [11:0] ridx);
		res_t        r;
		logic [31:0] addend;
		bit          known;
		bit          empty;
		int unsigned slot;
		int unsigned stride;
		int unsigned total;
		r = '0;
		empty = (setup.roi_cols == 0) || (setup.roi_rows == 0);
		if (k == KIND_READ) begin
			r.is_bin_read = 1'b1;
			r.frame_tag   = last_tag;
			r.bin_number  = ridx;
			r.bin_value   = (ridx < BIN_SLOTS) ? bin_sum[ridx] : '0;
			due_results.insert(due_results.size(), r);
		end else begin
			// first pixel of a frame wipes the store
			if (col_pos == 0 && row_pos == 0 && !row_past_end)
				clear_bins();
			if (!empty && !row_past_end &&
					col_pos >= setup.roi_left && col_pos - setup.roi_left < setup.roi_cols &&
					row_pos >= setup.roi_top && row_pos - setup.roi_top < setup.roi_rows) begin
				slot = setup.sum_mode ? row_pos - setup.roi_top : col_pos - setup.roi_left;
				known = extend_pixel(setup.pixel_format, raw, addend);
				if (slot < BIN_SLOTS && known)
					bin_sum[slot] = bin_sum[slot] + addend;
			end
			// raster position, stride clamped to 1..4096
			stride = setup.frame_cols;
			if (stride == 0)
				stride = 1;
			if (stride > STRIDE_MAX)
				stride = STRIDE_MAX;
			if (col_pos + 1 >= stride) begin
				col_pos = 0;
				if (row_pos >= ROW_LAST)
					row_past_end = 1'b1;
				else
					row_pos++;
			end else begin
				col_pos++;
			end
			if (fend) begin
				total = 0;
				if (!empty) begin
					total = setup.sum_mode ? setup.roi_rows : setup.roi_cols;
					if (total > BIN_SLOTS)
						total = BIN_SLOTS;
				end
				last_tag       = fid;
				col_pos        = 0;
				row_pos        = 0;
				row_past_end   = 1'b0;
				r.frame_tag    = fid;
				r.bin_total    = total[12:0];
				r.region_empty = empty;
				due_results.insert(due_results.size(), r);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	task automatic compare_word();
		res_t want;
		if (due_results.size() == 0) begin
			fault_count++;
			$error("result word with nothing expected: is_bin_read %0b frame_tag %0h",
				is_bin_read, frame_tag);
		end else begin
			want = due_results.pop_front();
			check_field("is_bin_read", want.is_bin_read, is_bin_read);
			check_field("frame_tag", want.frame_tag, frame_tag);
			check_field("bin_total", want.bin_total, bin_total);
			check_field("region_empty", want.region_empty, region_empty);
			check_field("bin_number", want.bin_number, bin_number);
			check_field("bin_value", want.bin_value, bin_value);
		end
	endtask

	// input word is predicted before the output word of the same edge is compared
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup              = '0;
			setup.frame_cols   = 13'd1;
			col_pos            = 0;
			row_pos            = 0;
			row_past_end       = 1'b0;
			last_tag           = '0;
			clear_bins();
			due_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				project_word(kind, pixel_raw, frame_end, frame_id, read_index);
			if (out_valid && out_ready)
				compare_word();
		end
		outstanding = due_results.size();
	end

endmodule

@@ bench/tb_roi_row_column_projection_unit.sv @@
// Stimulus and verdict for the ROI row/column projection unit; checking lives in the checker.
`timescale 1ns / 1ps

module tb_roi_row_column_projection_unit;
	import rrcp_pkg::*;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 120;
	localparam int RANDOM_WORDS  = 1150;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index  = REG_ROI_LEFT;
	logic [12:0] cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic        kind       = KIND_PIXEL;
	logic [31:0] pixel_raw  = '0;
	logic        frame_end  = 1'b0;
	logic [31:0] frame_id   = '0;
	logic [11:0] read_index = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic        is_bin_read;
	logic [31:0] frame_tag;
	logic [12:0] bin_total;
	logic        region_empty;
	logic [11:0] bin_number;
	logic signed [31:0] bin_value;

	int unsigned fault_count;
	int unsigned outstanding;

	// sender pacing and run totals
	int unsigned burst_left     = 0;
	bit          gaps_on        = 1'b1;
	int unsigned hold_requests  = 0;
	int unsigned hold_served    = 0;
	int unsigned words_sent     = 0;
	int unsigned frames_sent    = 0;
	int unsigned reads_sent     = 0;
	int unsigned setups_applied = 0;
	cfg_t        current;

	roi_row_column_projection_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pixel_raw    (pixel_raw),
		.frame_end    (frame_end),
		.frame_id     (frame_id),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_bin_read  (is_bin_read),
		.frame_tag    (frame_tag),
		.bin_total    (bin_total),
		.region_empty (region_empty),
		.bin_number   (bin_number),
		.bin_value    (bin_value)
	);

	rrcp_projection_check projection_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pixel_raw    (pixel_raw),
		.frame_end    (frame_end),
		.frame_id     (frame_id),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_bin_read  (is_bin_read),
		.frame_tag    (frame_tag),
		.bin_total    (bin_total),
		.region_empty (region_empty),
		.bin_number   (bin_number),
		.bin_value    (bin_value),
		.fault_count  (fault_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Run stopped at the cycle limit of %0d", LIMIT_CYCLES);
		$display("Mismatches found");
		$finish;
	end

	// result side: random stall masks, plus a long hold-off on request
	initial begin
		logic [31:0] stall_mask;
		int unsigned mask_left;
		mask_left = 0;
		stall_mask = '1;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served++;
			end else begin
				if (mask_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_mask = '1;
						1: stall_mask = $urandom;
						2: stall_mask = $urandom | $urandom;
						default: stall_mask = $urandom & $urandom;
					endcase
					mask_left = 32;
				end
				mask_left--;
				out_ready = stall_mask[mask_left];
			end
		end
	end

	// one input word; entered and left at a falling edge
	task automatic send_word(input logic k, input logic [31:0] raw, input logic fend,
			input logic [31:0] fid, input logic [11:0] ridx);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid   = 1'b1;
		kind       = k;
		pixel_raw  = raw;
		frame_end  = fend;
		frame_id   = fid;
		read_index = ridx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_read(input logic [11:0] ridx);
		send_word(KIND_READ, $urandom, 1'($urandom_range(0, 1)), $urandom, ridx);
		reads_sent++;
	endtask

	function automatic logic [31:0] pick_pixel();
		case ($urandom_range(0, 5))
			0: pick_pixel = 32'hFFFF_FFFF;
			1: pick_pixel = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
			2: pick_pixel = 32'h8000_8080;
			3: pick_pixel = 32'($urandom_range(0, 3));
			default: pick_pixel = $urandom;
		endcase
	endfunction

	function automatic logic [11:0] pick_index();
		pick_index = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
	endfunction

	// pixels of one frame with the odd bin read mixed in
	task automatic send_frame(input int unsigned length, input bit with_reads);
		for (int unsigned i = 0; i < length; i++) begin
			if (with_reads && $urandom_range(0, 5) == 0)
				send_read(pick_index());
			send_word(KIND_PIXEL, pick_pixel(), i == length - 1, $urandom, 12'($urandom));
		end
		frames_sent++;
	endtask

	// sender pauses until every result is back and the pipeline has settled
	task automatic wait_idle();
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_reg(input logic [2:0] idx, input logic [12:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_setup(input cfg_t s);
		wait_idle();
		push_reg(REG_ROI_LEFT, {1'b0, s.roi_left});
		push_reg(REG_ROI_TOP, {1'b0, s.roi_top});
		push_reg(REG_ROI_COLS, s.roi_cols);
		push_reg(REG_ROI_ROWS, s.roi_rows);
		push_reg(REG_SUM_MODE, {12'd0, s.sum_mode});
		push_reg(REG_FRAME_COLS, s.frame_cols);
		push_reg(REG_PIXEL_FORMAT, {10'd0, s.pixel_format});
		cfg_valid = 1'b0;
		current = s;
		setups_applied++;
	endtask

	function automatic cfg_t make_setup(input int unsigned left, input int unsigned top,
			input int unsigned cols, input int unsigned rows, input int unsigned mode,
			input int unsigned stride, input logic [2:0] fmt);
		cfg_t s;
		s.roi_left     = left[11:0];
		s.roi_top      = top[11:0];
		s.roi_cols     = cols[12:0];
		s.roi_rows     = rows[12:0];
		s.sum_mode     = mode[0];
		s.frame_cols   = stride[12:0];
		s.pixel_format = fmt;
		make_setup = s;
	endfunction

	function automatic int unsigned visible_stride(input cfg_t s);
		visible_stride = (s.frame_cols == 0) ? 1 : (s.frame_cols > 4096 ? 4096 : s.frame_cols);
	endfunction

	// small frames mostly, with the odd extreme register value
	function automatic cfg_t random_setup();
		cfg_t        s;
		int unsigned span;
		case ($urandom_range(0, 9))
			0: s.frame_cols = 13'd0;
			1: s.frame_cols = 13'd4096;
			2: s.frame_cols = 13'($urandom_range(4097, 8191));
			default: s.frame_cols = 13'($urandom_range(1, 8));
		endcase
		span = visible_stride(s);
		if (span > 8)
			span = 8;
		s.roi_left = ($urandom_range(0, 7) == 0) ? 12'd4095 : 12'($urandom_range(0, span));
		s.roi_cols = ($urandom_range(0, 7) == 0) ? 13'd4096 : 13'($urandom_range(0, span + 1));
		s.roi_top  = ($urandom_range(0, 7) == 0) ? 12'd4095 : 12'($urandom_range(0, 3));
		s.roi_rows = ($urandom_range(0, 7) == 0) ? 13'd4096 : 13'($urandom_range(0, 5));
		s.sum_mode = 1'($urandom_range(0, 1));
		s.pixel_format = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
			3'($urandom_range(0, 5));
		random_setup = s;
	endfunction

	initial begin
		int unsigned start_words;
		int unsigned phase_words;
		int unsigned span;
		int unsigned length;
		bit          held;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset state: reads of a cleared store, then a frame over an empty region
		send_read(12'd0);
		send_read(12'd4095);
		send_word(KIND_PIXEL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 12'd0);
		frames_sent++;

		// 3-wide frame, two-column region from column 1, signed bytes
		apply_setup(make_setup(1, 0, 2, 2, 0, 3, FMT_S8));
		send_word(KIND_PIXEL, 32'h0000_007F, 1'b0, 32'h0, 12'd0);
		send_word(KIND_PIXEL, 32'h0000_0080, 1'b0, 32'h0, 12'd0);
		send_word(KIND_PIXEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 12'd0);
		send_word(KIND_PIXEL, 32'h0000_0001, 1'b0, 32'h0, 12'd0);
		send_word(KIND_PIXEL, 32'h0000_007F, 1'b0, 32'h0, 12'd0);
		send_word(KIND_PIXEL, 32'hFFFF_FF80, 1'b1, 32'h0000_0001, 12'd0);
		frames_sent++;
		send_read(12'd0);
		send_read(12'd1);
		send_read(12'd2);

		// every pixel format, known and unknown, on one sign-probing pixel
		for (int f = 0; f < 8; f++) begin
			apply_setup(make_setup(0, 0, 1, 1, 1, 1, 3'(f)));
			send_word(KIND_PIXEL, 32'h8000_8080, 1'b1, 32'(f), 12'd0);
			frames_sent++;
			send_read(12'd0);
		end

		// random phases: well-formed frames with reads mixed in
		held = 1'b0;
		start_words = words_sent;
		while (words_sent - start_words < RANDOM_WORDS) begin
			apply_setup(random_setup());
			gaps_on = ($urandom_range(0, 3) != 0);
			if (!held) begin
				// long output stall while reads keep coming: fills the block
				held = 1'b1;
				gaps_on = 1'b0;
				burst_left = 0;
				hold_requests++;
				for (int i = 0; i < 30; i++)
					send_read(pick_index());
				gaps_on = 1'b1;
			end
			phase_words = words_sent + $urandom_range(100, 260);
			span = visible_stride(current);
			if (span > 8)
				span = 8;
			while (words_sent < phase_words) begin
				if ($urandom_range(0, 9) == 0)
					length = $urandom_range(1, 40);
				else
					length = $urandom_range(1, 3 * span + 2);
				send_frame(length, 1'b1);
			end
		end

		// column sums into a full-height set of row bins, one pixel per line
		apply_setup(make_setup(0, 0, 1, 4096, 1, 1, FMT_S16));
		send_frame(40, 1'b0);
		send_read(12'd0);
		send_read(12'd1);
		send_read(12'd39);
		send_read(12'd4095);

		// oversized stride clamps to 4096; full-width region in line-sum mode
		apply_setup(make_setup(0, 0, 4096, 2, 0, 8191, FMT_U32));
		send_frame(40, 1'b0);
		for (int i = 0; i < 8; i++)
			send_read(12'(i));

		wait_idle();
		$display("Covered %0d input words: %0d frames, %0d bin reads, %0d register settings,",
			words_sent, frames_sent, reads_sent, setups_applied);
		$display("with all pixel formats, both sum modes, clamped strides and full-size regions");
		if (fault_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rrcp_pkg.sv
rtl/rrcp_out_fifo.sv
rtl/rrcp_bin_store.sv
rtl/rrcp_front.sv
rtl/roi_row_column_projection_unit.sv
bench/rrcp_projection_check.sv
bench/tb_roi_row_column_projection_unit.sv
